FILE: sv/rflrs_pkg.sv
`default_nettype none
package rflrs_pkg;

   localparam int ADDR_W      = 64;
   localparam int LEN_W       = 12;
   localparam int OP_W        = 3;
   localparam int LB_W        = 7;
   localparam int CNT_W       = 64;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int QUEUE_DEPTH = 2;
   localparam int LINE_BYTES  = 64;

   localparam logic [OP_W-1:0] OP_LOAD       = 3'd0;
   localparam logic [OP_W-1:0] OP_STORE      = 3'd1;
   localparam logic [OP_W-1:0] OP_ATOMIC     = 3'd2;
   localparam logic [OP_W-1:0] OP_COPY_READ  = 3'd3;
   localparam logic [OP_W-1:0] OP_COPY_WRITE = 3'd4;
   localparam logic [OP_W-1:0] OP_FILL       = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_REGION_BASE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_SIZE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REMOTE_BASE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_ALL      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FORWARD_ENABLE = 3'd4;

   typedef struct packed {
      logic [CNT_W-1:0] reads;
      logic [CNT_W-1:0] writes;
      logic [CNT_W-1:0] atomics;
      logic [CNT_W-1:0] read_bytes;
      logic [CNT_W-1:0] write_bytes;
   } counters_type;

   typedef struct packed {
      logic              send;
      logic              wflag;
      logic [ADDR_W-1:0] addr;
      logic [LEN_W-1:0]  len;
      counters_type      cnt;
   } entry_type;

   typedef enum logic {
      BK_IDLE,
      BK_SPLIT
   } back_state_type;

endpackage
`default_nettype wire

FILE: sv/rflrs_front.sv
`default_nettype none
module rflrs_front
   import rflrs_pkg::*;
#(
   parameter int MAX_ACCESS_BYTES = 2048
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire logic [ADDR_W-1:0]     req_address,
   input  wire logic [LEN_W-1:0]      req_access_bytes,
   input  wire logic [OP_W-1:0]       req_opcode,
   input  wire logic                  q_full,
   output      logic                  q_push,
   output      entry_type             q_data
);

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_ACCESS_BYTES);

   logic [ADDR_W-1:0] region_base_ff;
   logic [ADDR_W-1:0] region_size_ff;
   logic [ADDR_W-1:0] remote_base_ff;
   logic              count_all_ff;
   logic              forward_enable_ff;
   logic [ADDR_W:0]   limit_ff;
   logic [ADDR_W-1:0] delta_ff;

   logic              s1_valid_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic [LEN_W-1:0]  s1_len_ff;
   logic [OP_W-1:0]   s1_op_ff;
   counters_type      cnt_ff;
   counters_type      cnt_in;

   logic              accept;
   logic [LEN_W-1:0]  len_clamped;
   logic              ignored;
   logic [ADDR_W:0]   last_byte;
   logic              hit;
   logic              is_rd;
   logic              is_wr;
   logic              is_atomic;
   logic              counted;

   always_ff @(posedge clock) begin
      if (reset) begin
         region_base_ff    <= '0;
         region_size_ff    <= '0;
         remote_base_ff    <= '0;
         count_all_ff      <= 1'b1;
         forward_enable_ff <= 1'b0;
         limit_ff          <= '0;
         delta_ff          <= '0;
      end else begin
         limit_ff <= {1'b0, region_base_ff} + {1'b0, region_size_ff};
         delta_ff <= remote_base_ff - region_base_ff;
         if (csr_write) begin
            unique case (csr_index)
               CSR_REGION_BASE:    region_base_ff    <= csr_wdata;
               CSR_REGION_SIZE:    region_size_ff    <= csr_wdata;
               CSR_REMOTE_BASE:    remote_base_ff    <= csr_wdata;
               CSR_COUNT_ALL:      count_all_ff      <= csr_wdata[0];
               CSR_FORWARD_ENABLE: forward_enable_ff <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      req_stall   = s1_valid_ff && q_full;
      q_push      = s1_valid_ff && !q_full;
      accept      = req_valid && !req_stall;
      len_clamped = (req_access_bytes > MAX_LEN) ? MAX_LEN : req_access_bytes;

      ignored   = (s1_addr_ff == '0) || (s1_len_ff == '0);
      last_byte = {1'b0, s1_addr_ff} + (ADDR_W + 1)'(s1_len_ff) - (ADDR_W + 1)'(1);
      if (region_size_ff == '0) begin
         hit = 1'b1;
      end else if (s1_addr_ff < region_base_ff) begin
         hit = 1'b0;
      end else if (last_byte[ADDR_W]) begin
         hit = 1'b0;
      end else begin
         hit = last_byte < limit_ff;
      end

      is_rd     = (s1_op_ff == OP_LOAD) || (s1_op_ff == OP_ATOMIC) ||
                  (s1_op_ff == OP_COPY_READ);
      is_wr     = (s1_op_ff == OP_STORE) || (s1_op_ff == OP_ATOMIC) ||
                  (s1_op_ff == OP_COPY_WRITE) || (s1_op_ff == OP_FILL);
      is_atomic = s1_op_ff == OP_ATOMIC;
      counted   = !ignored && (hit || count_all_ff);

      cnt_in             = cnt_ff;
      cnt_in.reads       = cnt_ff.reads + CNT_W'(counted && is_rd);
      cnt_in.writes      = cnt_ff.writes + CNT_W'(counted && is_wr);
      cnt_in.atomics     = cnt_ff.atomics + CNT_W'(counted && is_atomic);
      cnt_in.read_bytes  = cnt_ff.read_bytes +
                           ((counted && is_rd) ? CNT_W'(s1_len_ff) : '0);
      cnt_in.write_bytes = cnt_ff.write_bytes +
                           ((counted && is_wr) ? CNT_W'(s1_len_ff) : '0);

      q_data.send  = !ignored && hit && forward_enable_ff;
      q_data.wflag = is_wr && !is_rd;
      q_data.addr  = (region_size_ff == '0) ? s1_addr_ff : s1_addr_ff + delta_ff;
      q_data.len   = s1_len_ff;
      q_data.cnt   = cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         cnt_ff      <= '0;
      end else begin
         if (q_push) begin
            cnt_ff <= cnt_in;
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (q_push) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_addr_ff <= req_address;
         s1_len_ff  <= len_clamped;
         s1_op_ff   <= req_opcode;
      end
   end

endmodule
`default_nettype wire

FILE: sv/rflrs_queue.sv
`default_nettype none
module rflrs_queue
   import rflrs_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_data,
   input  wire logic      pop,
   output      entry_type pop_data,
   output      logic      full,
   output      logic      empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_QW-1:0] DEPTH_C = CNT_QW'(QUEUE_DEPTH);

   entry_type          mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_QW-1:0]  count_ff;
   logic               do_push;
   logic               do_pop;

   always_comb begin
      full     = count_ff == DEPTH_C;
      empty    = count_ff == '0;
      do_push  = push && !full;
      do_pop   = pop && !empty;
      pop_data = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_QW'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_QW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

FILE: sv/rflrs_back.sv
`default_nettype none
module rflrs_back
   import rflrs_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_empty,
   output      logic              q_pop,
   input  wire entry_type         q_data,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      logic              rsp_sent,
   output      logic              rsp_op_write,
   output      logic [ADDR_W-1:0] rsp_line_addr,
   output      logic [LB_W-1:0]   rsp_line_bytes,
   output      logic              rsp_last,
   output      logic [CNT_W-1:0]  rsp_reads_total,
   output      logic [CNT_W-1:0]  rsp_writes_total,
   output      logic [CNT_W-1:0]  rsp_atomics_total,
   output      logic [CNT_W-1:0]  rsp_read_bytes_total,
   output      logic [CNT_W-1:0]  rsp_write_bytes_total
);

   localparam int LW = $clog2(LINE_BYTES);
   localparam logic [LEN_W-1:0] LINE_LEN = LEN_W'(LINE_BYTES);

   back_state_type    state_ff;
   back_state_type    state_in;
   logic              send_ff;
   logic              wflag_ff;
   logic [ADDR_W-1:0] cur_ff;
   logic [LEN_W-1:0]  rem_ff;
   counters_type      cnt_ff;

   logic              rsp_valid_ff;
   logic              rsp_sent_ff;
   logic              rsp_op_write_ff;
   logic [ADDR_W-1:0] rsp_line_addr_ff;
   logic [LB_W-1:0]   rsp_line_bytes_ff;
   logic              rsp_last_ff;
   counters_type      rsp_cnt_ff;

   logic              out_free;
   logic [LEN_W-1:0]  room;
   logic [LEN_W-1:0]  take;
   logic              is_last;
   logic              emit;

   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      room     = LINE_LEN - LEN_W'(cur_ff[LW-1:0]);
      take     = (room > rem_ff) ? rem_ff : room;
      is_last  = !send_ff || (take == rem_ff);
      emit     = 1'b0;
      q_pop    = 1'b0;
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               state_in = BK_SPLIT;
            end
         end
         BK_SPLIT: begin
            if (out_free) begin
               emit = 1'b1;
               if (is_last) begin
                  q_pop    = !q_empty;
                  state_in = q_empty ? BK_IDLE : BK_SPLIT;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         send_ff  <= q_data.send;
         wflag_ff <= q_data.wflag;
         cur_ff   <= q_data.addr;
         rem_ff   <= q_data.len;
         cnt_ff   <= q_data.cnt;
      end else if (emit) begin
         cur_ff <= cur_ff + ADDR_W'(take);
         rem_ff <= rem_ff - take;
      end
      if (emit) begin
         rsp_sent_ff       <= send_ff;
         rsp_op_write_ff   <= send_ff && wflag_ff;
         rsp_line_addr_ff  <= send_ff ? cur_ff : '0;
         rsp_line_bytes_ff <= send_ff ? take[LB_W-1:0] : '0;
         rsp_last_ff       <= is_last;
         rsp_cnt_ff        <= cnt_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_sent              = rsp_sent_ff;
   assign rsp_op_write          = rsp_op_write_ff;
   assign rsp_line_addr         = rsp_line_addr_ff;
   assign rsp_line_bytes        = rsp_line_bytes_ff;
   assign rsp_last              = rsp_last_ff;
   assign rsp_reads_total       = rsp_cnt_ff.reads;
   assign rsp_writes_total      = rsp_cnt_ff.writes;
   assign rsp_atomics_total     = rsp_cnt_ff.atomics;
   assign rsp_read_bytes_total  = rsp_cnt_ff.read_bytes;
   assign rsp_write_bytes_total = rsp_cnt_ff.write_bytes;

   // Entries are only taken from a queue that holds one.
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_empty)
      else $error("pop from empty queue");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_sent_ff |->
         rsp_last_ff && !rsp_op_write_ff && (rsp_line_bytes_ff == '0))
      else $error("non-sent beat is not a single final beat");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_SPLIT) && send_ff |-> rem_ff != '0)
      else $error("split active with no bytes left");

   // After a chunk that is not the last one, the next request starts on a line boundary.
   assert property (@(posedge clock) disable iff (reset)
      emit && send_ff && !is_last |=> cur_ff[LW-1:0] == '0)
      else $error("split left an unaligned continuation");

endmodule
`default_nettype wire

FILE: sv/region_filtered_line_request_splitter.sv
// Region-filtered line request splitter.
// Input beats on the req_ channel carry one memory access: address, byte count and
// opcode. Each access yields one or more result beats on the rsp_ channel. A selected
// access with forwarding enabled becomes one request beat per touched line, the last
// marked by rsp_last; every other access yields one non-sent beat. Each beat carries the
// running read, write, atomic and byte totals as they stand after its access.
// The user must see that registers are written through the csr_ port while no access is
// in flight; the block itself does not enforce this. The front stage registers and
// classifies an access, updates the totals and queues it; the back stage splits queued
// accesses and drives a registered result beat. The back stage issues one result beat
// per cycle while rsp_ is not stalled, one per line an access touches, and the front
// stage takes one access per cycle while the two-entry queue has room.
// A stall on rsp_ holds the current beat; the queue then fills and req_stall rises.
// Synchronous reset empties the queue, drops any pending beat, clears all totals and
// returns the registers to their reset values (count_all set, forwarding off).
`default_nettype none
module region_filtered_line_request_splitter
   import rflrs_pkg::*;
#(
   parameter int MAX_ACCESS_BYTES = 2048
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire logic [ADDR_W-1:0]     req_address,
   input  wire logic [LEN_W-1:0]      req_access_bytes,
   input  wire logic [OP_W-1:0]       req_opcode,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      logic                  rsp_sent,
   output      logic                  rsp_op_write,
   output      logic [ADDR_W-1:0]     rsp_line_addr,
   output      logic [LB_W-1:0]       rsp_line_bytes,
   output      logic                  rsp_last,
   output      logic [CNT_W-1:0]      rsp_reads_total,
   output      logic [CNT_W-1:0]      rsp_writes_total,
   output      logic [CNT_W-1:0]      rsp_atomics_total,
   output      logic [CNT_W-1:0]      rsp_read_bytes_total,
   output      logic [CNT_W-1:0]      rsp_write_bytes_total
);

   logic      q_full;
   logic      q_empty;
   logic      q_push;
   logic      q_pop;
   entry_type q_push_data;
   entry_type q_pop_data;

   rflrs_front #(
      .MAX_ACCESS_BYTES(MAX_ACCESS_BYTES)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_address     (req_address),
      .req_access_bytes(req_access_bytes),
      .req_opcode      (req_opcode),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_data          (q_push_data)
   );

   rflrs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_push_data),
      .pop      (q_pop),
      .pop_data (q_pop_data),
      .full     (q_full),
      .empty    (q_empty)
   );

   rflrs_back u_back (
      .clock                (clock),
      .reset                (reset),
      .q_empty              (q_empty),
      .q_pop                (q_pop),
      .q_data               (q_pop_data),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_sent             (rsp_sent),
      .rsp_op_write         (rsp_op_write),
      .rsp_line_addr        (rsp_line_addr),
      .rsp_line_bytes       (rsp_line_bytes),
      .rsp_last             (rsp_last),
      .rsp_reads_total      (rsp_reads_total),
      .rsp_writes_total     (rsp_writes_total),
      .rsp_atomics_total    (rsp_atomics_total),
      .rsp_read_bytes_total (rsp_read_bytes_total),
      .rsp_write_bytes_total(rsp_write_bytes_total)
   );

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import rflrs_pkg::*;

   localparam logic [63:0] LINE_BYTES       = 64;
   localparam logic [63:0] MAX_ACCESS_BYTES = 2048;
   localparam logic [OP_W-1:0] OP_UNKNOWN_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_UNKNOWN_7 = 3'd7;
   localparam int SETTLE_CYCLES = 6;
   localparam int QUIET_LIMIT   = 5000;
   localparam int PHASE_ITEMS   = 28;

   typedef struct packed {
      logic              sent;
      logic              op_write;
      logic [ADDR_W-1:0] line_addr;
      logic [LB_W-1:0]   line_bytes;
      logic              last;
      counters_type      totals;
   } line_beat_type;

   typedef enum logic {
      ROW_ACCESS,
      ROW_CSR
   } row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  reg_index;
      logic [63:0]           value;
      logic [LEN_W-1:0]      nbytes;
      logic [OP_W-1:0]       opcode;
      bit                    known;
      counters_type          known_cnt;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_write;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  req_valid;
   logic                  req_stall;
   logic [ADDR_W-1:0]     req_address;
   logic [LEN_W-1:0]      req_access_bytes;
   logic [OP_W-1:0]       req_opcode;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_sent;
   logic                  rsp_op_write;
   logic [ADDR_W-1:0]     rsp_line_addr;
   logic [LB_W-1:0]       rsp_line_bytes;
   logic                  rsp_last;
   logic [CNT_W-1:0]      rsp_reads_total;
   logic [CNT_W-1:0]      rsp_writes_total;
   logic [CNT_W-1:0]      rsp_atomics_total;
   logic [CNT_W-1:0]      rsp_read_bytes_total;
   logic [CNT_W-1:0]      rsp_write_bytes_total;

   logic [63:0]  cfg_region_base;
   logic [63:0]  cfg_region_size;
   logic [63:0]  cfg_remote_base;
   logic         cfg_count_all;
   logic         cfg_forward_enable;
   counters_type totals;

   line_beat_type pending_beats[$];
   stim_row_type  rows[$];
   int            error_count = 0;
   int            quiet_cycles = 0;
   int            send_idle_pct = 0;
   int            stall_pct = 0;

   region_filtered_line_request_splitter i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write             (csr_write),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_address           (req_address),
      .req_access_bytes      (req_access_bytes),
      .req_opcode            (req_opcode),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_sent              (rsp_sent),
      .rsp_op_write          (rsp_op_write),
      .rsp_line_addr         (rsp_line_addr),
      .rsp_line_bytes        (rsp_line_bytes),
      .rsp_last              (rsp_last),
      .rsp_reads_total       (rsp_reads_total),
      .rsp_writes_total      (rsp_writes_total),
      .rsp_atomics_total     (rsp_atomics_total),
      .rsp_read_bytes_total  (rsp_read_bytes_total),
      .rsp_write_bytes_total (rsp_write_bytes_total)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit region_selects(input logic [63:0] addr, input logic [63:0] len);
      logic [63:0] last_byte;
      logic [64:0] limit;
      if (cfg_region_size == 0) return 1'b1;
      if (addr < cfg_region_base) return 1'b0;
      last_byte = addr + len - 64'd1;
      if (last_byte < addr) return 1'b0;
      limit = {1'b0, cfg_region_base} + {1'b0, cfg_region_size};
      return {1'b0, last_byte} < limit;
   endfunction

   // Updates the running totals and produces the beats that one access causes.
   function automatic void split_access(input logic [63:0] addr,
                                        input logic [LEN_W-1:0] nbytes,
                                        input logic [OP_W-1:0] op,
                                        ref line_beat_type beats[$]);
      logic [63:0]   len;
      logic [63:0]   cur;
      logic [63:0]   chunk;
      logic [63:0]   remaining;
      bit            selected;
      bit            is_rd;
      bit            is_wr;
      line_beat_type beat;
      beats.delete();
      len = 64'(nbytes);
      if (len > MAX_ACCESS_BYTES) len = MAX_ACCESS_BYTES;
      beat = '0;
      beat.last = 1'b1;
      if (addr == 0 || len == 0) begin
         beat.totals = totals;
         beats.push_back(beat);
         return;
      end
      selected = region_selects(addr, len);
      is_rd = op inside {OP_LOAD, OP_ATOMIC, OP_COPY_READ};
      is_wr = op inside {OP_STORE, OP_ATOMIC, OP_COPY_WRITE, OP_FILL};
      if (selected || cfg_count_all) begin
         if (is_rd) begin
            totals.reads += 64'd1;
            totals.read_bytes += len;
         end
         if (is_wr) begin
            totals.writes += 64'd1;
            totals.write_bytes += len;
         end
         if (op == OP_ATOMIC) totals.atomics += 64'd1;
      end
      if (!(selected && cfg_forward_enable)) begin
         beat.totals = totals;
         beats.push_back(beat);
         return;
      end
      cur = (cfg_region_size == 0) ? addr : cfg_remote_base + (addr - cfg_region_base);
      remaining = len;
      while (remaining != 0) begin
         chunk = LINE_BYTES - (cur % LINE_BYTES);
         if (chunk > remaining) chunk = remaining;
         remaining -= chunk;
         beat.sent = 1'b1;
         beat.op_write = is_wr && !is_rd;
         beat.line_addr = cur;
         beat.line_bytes = chunk[LB_W-1:0];
         beat.last = (remaining == 0);
         beat.totals = totals;
         beats.push_back(beat);
         cur += chunk;
      end
   endfunction

   function automatic stim_row_type acc(input logic [63:0] addr,
                                        input logic [LEN_W-1:0] nbytes,
                                        input logic [OP_W-1:0] op);
      stim_row_type row;
      row.kind = ROW_ACCESS;
      row.reg_index = '0;
      row.value = addr;
      row.nbytes = nbytes;
      row.opcode = op;
      row.known = 1'b0;
      row.known_cnt = '0;
      return row;
   endfunction

   function automatic stim_row_type acc_known(input logic [63:0] addr,
                                              input logic [LEN_W-1:0] nbytes,
                                              input logic [OP_W-1:0] op,
                                              input logic [63:0] r, input logic [63:0] w,
                                              input logic [63:0] a, input logic [63:0] rb,
                                              input logic [63:0] wb);
      stim_row_type row;
      row = acc(addr, nbytes, op);
      row.known = 1'b1;
      row.known_cnt = '{r, w, a, rb, wb};
      return row;
   endfunction

   function automatic stim_row_type set_reg(input logic [CSR_IDX_W-1:0] idx,
                                            input logic [63:0] value);
      stim_row_type row;
      row = acc('0, '0, OP_LOAD);
      row.kind = ROW_CSR;
      row.reg_index = idx;
      row.value = value;
      return row;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %0s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want)
         report_mismatch($sformatf("%0s got %h, expected %h", name, got, want));
   endtask

   task automatic check_beat();
      line_beat_type want;
      if (pending_beats.size() == 0) begin
         report_mismatch($sformatf("unexpected beat, line address %h", rsp_line_addr));
         return;
      end
      want = pending_beats.pop_front();
      check_field("sent", 64'(rsp_sent), 64'(want.sent));
      check_field("op_write", 64'(rsp_op_write), 64'(want.op_write));
      check_field("line_addr", rsp_line_addr, want.line_addr);
      check_field("line_bytes", 64'(rsp_line_bytes), 64'(want.line_bytes));
      check_field("last", 64'(rsp_last), 64'(want.last));
      check_field("reads_total", rsp_reads_total, want.totals.reads);
      check_field("writes_total", rsp_writes_total, want.totals.writes);
      check_field("atomics_total", rsp_atomics_total, want.totals.atomics);
      check_field("read_bytes_total", rsp_read_bytes_total, want.totals.read_bytes);
      check_field("write_bytes_total", rsp_write_bytes_total, want.totals.write_bytes);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_beat();
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Leaves csr_write high; the caller lowers it after the last write of a group.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_REGION_BASE:    cfg_region_base = value;
         CSR_REGION_SIZE:    cfg_region_size = value;
         CSR_REMOTE_BASE:    cfg_remote_base = value;
         CSR_COUNT_ALL:      cfg_count_all = value[0];
         CSR_FORWARD_ENABLE: cfg_forward_enable = value[0];
         default: ;
      endcase
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_beats.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_access(input logic [63:0] addr, input logic [LEN_W-1:0] nbytes,
                              input logic [OP_W-1:0] op, input bit known = 1'b0,
                              input counters_type known_cnt = '0);
      line_beat_type beats[$];
      line_beat_type fixed_beat;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_address <= addr;
      req_access_bytes <= nbytes;
      req_opcode <= op;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      split_access(addr, nbytes, op, beats);
      if (known) begin
         fixed_beat = '0;
         fixed_beat.last = 1'b1;
         fixed_beat.totals = known_cnt;
         pending_beats.push_back(fixed_beat);
      end else begin
         foreach (beats[k]) pending_beats.push_back(beats[k]);
      end
   endtask

   initial begin
      logic [63:0]      addr;
      logic [63:0]      value;
      logic [LEN_W-1:0] nbytes;
      logic [OP_W-1:0]  op;
      int               counted;
      bit               paused;
      int               idle_modes[4][2];

      idle_modes = '{'{0, 0}, '{55, 0}, '{0, 55}, '{9, 9}};
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_address = '0;
      req_access_bytes = '0;
      req_opcode = OP_LOAD;
      cfg_region_base = '0;
      cfg_region_size = '0;
      cfg_remote_base = '0;
      cfg_count_all = 1'b1;
      cfg_forward_enable = 1'b0;
      totals = '0;

      rows.push_back(acc_known(64'h0, 12'd16, OP_LOAD, 0, 0, 0, 0, 0));
      rows.push_back(acc_known(64'h1000, 12'd0, OP_STORE, 0, 0, 0, 0, 0));
      rows.push_back(acc_known(64'h40, 12'd8, OP_LOAD, 1, 0, 0, 8, 0));
      rows.push_back(acc_known(64'hFFFF_FFFF_FFFF_FFFF, 12'hFFF, OP_ATOMIC,
                               2, 1, 1, 2056, 2048));
      rows.push_back(acc_known(64'h1, 12'd1, OP_STORE, 2, 2, 1, 2056, 2049));
      rows.push_back(acc_known(64'h80, 12'd16, OP_UNKNOWN_6, 2, 2, 1, 2056, 2049));
      rows.push_back(acc_known(64'h8000_0000_0000_0000, 12'd2048, OP_UNKNOWN_7,
                               2, 2, 1, 2056, 2049));
      rows.push_back(set_reg(CSR_FORWARD_ENABLE, 64'd1));
      rows.push_back(acc(64'h1000_0030, 12'd100, OP_COPY_READ));
      rows.push_back(acc(64'hFFFF_FFFF_FFFF_FFF0, 12'd64, OP_FILL));
      rows.push_back(acc(64'h2001, 12'd2048, OP_COPY_WRITE));
      rows.push_back(acc(64'h3000, 12'hFFF, OP_ATOMIC));
      rows.push_back(acc(64'h5, 12'd7, OP_UNKNOWN_6));
      rows.push_back(set_reg(CSR_REGION_BASE, 64'h1_0000));
      rows.push_back(set_reg(CSR_REGION_SIZE, 64'h1000));
      rows.push_back(set_reg(CSR_REMOTE_BASE, 64'hFFFF_FFFF_FFFF_FFC0));
      rows.push_back(set_reg(CSR_COUNT_ALL, 64'd0));
      rows.push_back(acc(64'h1_0000, 12'd64, OP_LOAD));
      rows.push_back(acc(64'h1_0FC0, 12'd64, OP_STORE));
      rows.push_back(acc(64'h1_0FC1, 12'd64, OP_STORE));
      rows.push_back(acc(64'hFFFF, 12'd4, OP_LOAD));
      rows.push_back(acc(64'h1_0080, 12'd200, OP_ATOMIC));
      rows.push_back(set_reg(CSR_COUNT_ALL, 64'd1));
      rows.push_back(set_reg(CSR_REGION_BASE, 64'hFFFF_FFFF_FFFF_F000));
      rows.push_back(set_reg(CSR_REGION_SIZE, 64'hFFFF_FFFF_FFFF_FFFF));
      rows.push_back(acc(64'hFFFF_FFFF_FFFF_FF00, 12'd256, OP_COPY_READ));
      rows.push_back(acc(64'hFFFF_FFFF_FFFF_FF01, 12'd256, OP_LOAD));
      rows.push_back(acc(64'h10, 12'd8, OP_FILL));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < rows.size(); i++) begin
         if (rows[i].kind == ROW_CSR) begin
            if (i == 0 || rows[i-1].kind != ROW_CSR) drain_pipeline();
            write_reg(rows[i].reg_index, rows[i].value);
            if (i + 1 == rows.size() || rows[i+1].kind != ROW_CSR) csr_write <= 1'b0;
         end else begin
            send_access(rows[i].value, rows[i].nbytes, rows[i].opcode, rows[i].known,
                        rows[i].known_cnt);
         end
      end

      for (int phase = 0; phase < 4; phase++) begin
         drain_pipeline();
         case (phase)
            0: begin
               write_reg(CSR_REGION_BASE, {$urandom, $urandom});
               write_reg(CSR_REGION_SIZE, 64'd0);
            end
            1: begin
               write_reg(CSR_REGION_BASE, {$urandom, $urandom} & ~64'hFFF);
               write_reg(CSR_REGION_SIZE, 64'($urandom_range(1, 64)) * 64'h1000);
            end
            2: begin
               write_reg(CSR_REGION_BASE, {$urandom, $urandom});
               write_reg(CSR_REGION_SIZE, 64'hFFFF_FFFF_FFFF_FFFF);
            end
            default: begin
               write_reg(CSR_REGION_BASE, 64'($urandom_range(1, 4096)));
               write_reg(CSR_REGION_SIZE, 64'($urandom_range(1, 8192)));
            end
         endcase
         write_reg(CSR_REMOTE_BASE, (phase == 2) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                 : {$urandom, $urandom});
         value = {$urandom, $urandom};
         value[0] = 1'($urandom_range(1));
         write_reg(CSR_COUNT_ALL, value);
         value = {$urandom, $urandom};
         value[0] = (phase < 3) ? 1'b1 : 1'($urandom_range(1));
         write_reg(CSR_FORWARD_ENABLE, value);
         csr_write <= 1'b0;
         send_idle_pct = idle_modes[phase][0];
         stall_pct = idle_modes[phase][1];

         counted = 0;
         paused = 1'b0;
         while (counted < PHASE_ITEMS) begin
            if (counted == PHASE_ITEMS / 2 && !paused) begin
               drain_pipeline();
               paused = 1'b1;
            end
            case ($urandom_range(9))
               7: addr = cfg_region_base + cfg_region_size - 64'($urandom_range(128));
               8: addr = cfg_region_base - 64'($urandom_range(1, 64));
               9: addr = ($urandom_range(1) != 0) ? {$urandom, $urandom}
                                                  : -64'($urandom_range(1, 256));
               default: addr = (cfg_region_size == 0) ? {$urandom, $urandom}
                                : cfg_region_base + ({$urandom, $urandom} % cfg_region_size);
            endcase
            case ($urandom_range(19))
               0: nbytes = LEN_W'($urandom_range(2049, 4095));
               1: nbytes = LEN_W'(MAX_ACCESS_BYTES);
               2, 3, 4, 5: nbytes = LEN_W'($urandom_range(65, 512));
               default: nbytes = LEN_W'($urandom_range(1, 64));
            endcase
            if ($urandom_range(29) == 0) addr = '0;
            if ($urandom_range(29) == 0) nbytes = '0;
            op = ($urandom_range(9) == 0) ? OP_W'($urandom_range(6, 7))
                                          : OP_W'($urandom_range(5));
            if (addr != 0 && nbytes != 0) counted++;
            send_access(addr, nbytes, op);
         end
      end

      drain_pipeline();
      if (error_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/rflrs_pkg.sv
sv/rflrs_front.sv
sv/rflrs_queue.sv
sv/rflrs_back.sv
sv/region_filtered_line_request_splitter.sv
tb/sv/testbench.sv
